// ===== rtl/world_transform_compose_unit_macros.svh =====
// Assertion macros for the world transform compose unit.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef WORLD_TRANSFORM_COMPOSE_UNIT_MACROS_SVH
`define WORLD_TRANSFORM_COMPOSE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wtc: assertion failed");
`define WTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wtc: assertion failed");
`else
`define WTC_ASSERT(lbl, prop)
`define WTC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/wtc_pkg.sv =====
// ----------------------------------------------------------------------------
// wtc_pkg
// Shared types, angle constants and fixed-point helpers for the
// world transform compose unit.
// ----------------------------------------------------------------------------
package wtc_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int FRAC_BITS_DEF    = 16;

  // Angle scale: 30 fraction bits
  localparam int     ANG_BITS    = 30;
  localparam longint ANG_HALF_PI = 64'd1686629713;
  localparam longint ANG_PI      = 64'd3373259426;
  localparam longint ANG_TWO_PI  = 64'd6746518852;
  localparam longint CORDIC_GAIN = 64'd652032874;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // Truncated arctangent table, 30 fraction bits
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
  };

  // Request fields that ride along the pipe
  typedef struct packed {
    logic [63:0] scale_pair;
    logic [63:0] position_pair;
    logic [63:0] pivot_pair;
    logic [16:0] node_alpha;
    logic        has_parent;
    logic [63:0] parent_ab;
    logic [63:0] parent_cd;
    logic [63:0] parent_offset;
    logic [16:0] parent_alpha;
  } pay_t;

  typedef struct packed {
    logic signed [33:0] z;
    logic               flip;
  } ang_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic               flip;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
  } mat_t;

  typedef struct packed {
    logic signed [31:0] pa;
    logic signed [31:0] pb;
    logic signed [31:0] pc;
    logic signed [31:0] pd;
    logic signed [31:0] ptx;
    logic signed [31:0] pty;
  } par_t;

  // Clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Sine or cosine times a scale, rounded at 30 bits and clamped
  function automatic logic signed [31:0] trig_mul(input logic signed [33:0] t,
                                                 input logic signed [31:0] s);
    logic signed [65:0] p;
    p = 66'(t) * 66'(s);
    p = (p + (66'sd1 <<< (ANG_BITS - 1))) >>> ANG_BITS;
    return sat32(p);
  endfunction

  // Q product, half rounds up
  function automatic logic signed [63:0] qmul(input logic signed [31:0] x,
                                             input logic signed [31:0] y,
                                             input int fb);
    logic signed [63:0] p;
    p = 64'(x) * 64'(y);
    p = (p + (64'sd1 <<< (fb - 1))) >>> fb;
    return p;
  endfunction

endpackage

// ===== rtl/world_transform_compose_unit.sv =====
// ----------------------------------------------------------------------------
// world_transform_compose_unit: local affine from rotation/scale/pivot, composed with parent.
// Pipeline: angle reduction, CORDIC, then stages T, L, M, W and O.
// Throughput: one request per cycle while out_stall is low; the angle and CORDIC pipes set the depth.
// Reset (synchronous, rst_n low) clears only the stage valid bits.
// ----------------------------------------------------------------------------
`include "world_transform_compose_unit_macros.svh"
module world_transform_compose_unit import wtc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_rotation,
  input  logic [63:0] in_scale_pair,
  input  logic [63:0] in_position_pair,
  input  logic [63:0] in_pivot_pair,
  input  logic [16:0] in_node_alpha,
  input  logic        in_has_parent,
  input  logic [63:0] in_parent_ab,
  input  logic [63:0] in_parent_cd,
  input  logic [63:0] in_parent_offset,
  input  logic [16:0] in_parent_alpha,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_world_ab,
  output logic [63:0] out_world_cd,
  output logic [63:0] out_world_offset,
  output logic [16:0] out_world_alpha
);

  localparam int PW = 65 - FRAC_BITS;
  localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

  pay_t  in_pay;
  logic  ang_in_ready;
  logic  ang_valid;
  logic  ang_ready;
  ang_t  ang;
  pay_t  ang_pay;
  logic  cor_valid;
  logic  cor_ready;
  trig_t cor;
  pay_t  cor_pay;

  logic [4:0] vld_r;
  logic [5:0] rdy;

  assign in_pay = '{
    scale_pair:    in_scale_pair,
    position_pair: in_position_pair,
    pivot_pair:    in_pivot_pair,
    node_alpha:    in_node_alpha,
    has_parent:    in_has_parent,
    parent_ab:     in_parent_ab,
    parent_cd:     in_parent_cd,
    parent_offset: in_parent_offset,
    parent_alpha:  in_parent_alpha
  };

  // Angle reduction
  wtc_angle #(.FRAC_BITS(FRAC_BITS)) u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (ang_in_ready),
    .in_rot    (in_rotation),
    .in_pay    (in_pay),
    .out_valid (ang_valid),
    .out_ready (ang_ready),
    .out_ang   (ang),
    .out_pay   (ang_pay)
  );
  assign in_stall = !ang_in_ready;

  // Sine and cosine
  wtc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ang_valid),
    .in_ready  (ang_ready),
    .in_ang    (ang),
    .in_pay    (ang_pay),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .out_trig  (cor),
    .out_pay   (cor_pay)
  );

  // Ready chain for the back stages
  assign rdy[5] = !out_stall;
  for (genvar k = 0; k < 5; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end
  assign cor_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= cor_valid;
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage T: local matrix from sine, cosine and scale
  mat_t  t_mat_r;
  pay_t  t_pay_r;
  always_ff @(posedge clk) begin
    logic signed [33:0] cs;
    logic signed [33:0] sn;
    if (rdy[0]) begin
      cs = cor.flip ? -cor.x : cor.x;
      sn = cor.flip ? -cor.y : cor.y;
      t_mat_r.a <= trig_mul(cs, $signed(cor_pay.scale_pair[63:32]));
      t_mat_r.b <= trig_mul(sn, $signed(cor_pay.scale_pair[63:32]));
      t_mat_r.c <= trig_mul(-sn, $signed(cor_pay.scale_pair[31:0]));
      t_mat_r.d <= trig_mul(cs, $signed(cor_pay.scale_pair[31:0]));
      t_pay_r   <= cor_pay;
    end
  end

  // Stage L: pivot products, parent select, alpha product
  mat_t               l_mat_r;
  logic signed [PW-1:0] l_q_r [4];
  par_t               l_par_r;
  logic [16:0]        l_alpha_r;
  logic [63:0]        l_pos_r;
  always_ff @(posedge clk) begin
    logic signed [63:0] q0;
    logic signed [63:0] q1;
    logic signed [63:0] q2;
    logic signed [63:0] q3;
    logic [34:0]        ap;
    logic [18:0]        ar;
    if (rdy[1]) begin
      q0 = qmul($signed(t_pay_r.pivot_pair[63:32]), t_mat_r.a, FRAC_BITS);
      q1 = qmul($signed(t_pay_r.pivot_pair[31:0]), t_mat_r.c, FRAC_BITS);
      q2 = qmul($signed(t_pay_r.pivot_pair[63:32]), t_mat_r.b, FRAC_BITS);
      q3 = qmul($signed(t_pay_r.pivot_pair[31:0]), t_mat_r.d, FRAC_BITS);
      l_q_r[0] <= q0[PW-1:0];
      l_q_r[1] <= q1[PW-1:0];
      l_q_r[2] <= q2[PW-1:0];
      l_q_r[3] <= q3[PW-1:0];
      l_mat_r  <= t_mat_r;
      l_pos_r  <= t_pay_r.position_pair;
      if (t_pay_r.has_parent) begin
        l_par_r.pa  <= $signed(t_pay_r.parent_ab[63:32]);
        l_par_r.pb  <= $signed(t_pay_r.parent_ab[31:0]);
        l_par_r.pc  <= $signed(t_pay_r.parent_cd[63:32]);
        l_par_r.pd  <= $signed(t_pay_r.parent_cd[31:0]);
        l_par_r.ptx <= $signed(t_pay_r.parent_offset[63:32]);
        l_par_r.pty <= $signed(t_pay_r.parent_offset[31:0]);
        ap = 35'(t_pay_r.node_alpha) * 35'(t_pay_r.parent_alpha) + 35'd32768;
      end else begin
        l_par_r.pa  <= Q_ONE;
        l_par_r.pb  <= '0;
        l_par_r.pc  <= '0;
        l_par_r.pd  <= Q_ONE;
        l_par_r.ptx <= '0;
        l_par_r.pty <= '0;
        ap = {2'b0, t_pay_r.node_alpha, 16'b0};
      end
      ar = ap[34:16];
      l_alpha_r <= (ar > 19'(ALPHA_ONE)) ? ALPHA_ONE : ar[16:0];
    end
  end

  // Stage M: local translation
  mat_t               m_mat_r;
  logic signed [31:0] m_tx_r;
  logic signed [31:0] m_ty_r;
  par_t               m_par_r;
  logic [16:0]        m_alpha_r;
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      m_tx_r    <= sat32(66'($signed(l_pos_r[63:32]))
                         - (66'(l_q_r[0]) + 66'(l_q_r[1])));
      m_ty_r    <= sat32(66'($signed(l_pos_r[31:0]))
                         - (66'(l_q_r[2]) + 66'(l_q_r[3])));
      m_mat_r   <= l_mat_r;
      m_par_r   <= l_par_r;
      m_alpha_r <= l_alpha_r;
    end
  end

  // Stage W: products with the parent matrix
  logic signed [PW-1:0] w_q_r [12];
  logic signed [31:0]   w_ptx_r;
  logic signed [31:0]   w_pty_r;
  logic [16:0]          w_alpha_r;
  always_ff @(posedge clk) begin
    logic signed [63:0] p [12];
    if (rdy[3]) begin
      p[0]  = qmul(m_mat_r.a, m_par_r.pa, FRAC_BITS);
      p[1]  = qmul(m_mat_r.b, m_par_r.pc, FRAC_BITS);
      p[2]  = qmul(m_mat_r.a, m_par_r.pb, FRAC_BITS);
      p[3]  = qmul(m_mat_r.b, m_par_r.pd, FRAC_BITS);
      p[4]  = qmul(m_mat_r.c, m_par_r.pa, FRAC_BITS);
      p[5]  = qmul(m_mat_r.d, m_par_r.pc, FRAC_BITS);
      p[6]  = qmul(m_mat_r.c, m_par_r.pb, FRAC_BITS);
      p[7]  = qmul(m_mat_r.d, m_par_r.pd, FRAC_BITS);
      p[8]  = qmul(m_tx_r, m_par_r.pa, FRAC_BITS);
      p[9]  = qmul(m_ty_r, m_par_r.pc, FRAC_BITS);
      p[10] = qmul(m_tx_r, m_par_r.pb, FRAC_BITS);
      p[11] = qmul(m_ty_r, m_par_r.pd, FRAC_BITS);
      for (int i = 0; i < 12; i++) begin
        w_q_r[i] <= p[i][PW-1:0];
      end
      w_ptx_r   <= m_par_r.ptx;
      w_pty_r   <= m_par_r.pty;
      w_alpha_r <= m_alpha_r;
    end
  end

  // Stage O: sums, saturation, output register
  logic [63:0] o_ab_r;
  logic [63:0] o_cd_r;
  logic [63:0] o_off_r;
  logic [16:0] o_alpha_r;
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      o_ab_r  <= {sat32(66'(w_q_r[0]) + 66'(w_q_r[1])),
                  sat32(66'(w_q_r[2]) + 66'(w_q_r[3]))};
      o_cd_r  <= {sat32(66'(w_q_r[4]) + 66'(w_q_r[5])),
                  sat32(66'(w_q_r[6]) + 66'(w_q_r[7]))};
      o_off_r <= {sat32(66'(w_q_r[8]) + 66'(w_q_r[9]) + 66'(w_ptx_r)),
                  sat32(66'(w_q_r[10]) + 66'(w_q_r[11]) + 66'(w_pty_r))};
      o_alpha_r <= w_alpha_r;
    end
  end

  assign out_valid        = vld_r[4];
  assign out_world_ab     = o_ab_r;
  assign out_world_cd     = o_cd_r;
  assign out_world_offset = o_off_r;
  assign out_world_alpha  = o_alpha_r;

  // Checks
  `WTC_ASSERT(a_stall_means_full, in_stall |-> (out_valid && out_stall))
  `WTC_ASSERT(a_alpha_bound, out_valid |-> (out_world_alpha <= ALPHA_ONE))
  `WTC_ASSERT_NEXT(a_held_stage_keeps, vld_r[2] && !rdy[2], vld_r[2])
  `WTC_ASSERT_NEXT(a_back_pressure, cor_valid && !cor_ready, vld_r[0] && vld_r[4])

endmodule

// ===== rtl/wtc_angle.sv =====
// ----------------------------------------------------------------------------
// wtc_angle
// Reduces a rotation to one turn (quotient by reciprocal multiply, then an
// exact remainder and a one-step correction) and folds it into -pi/2..pi/2
// with a flip flag. Three register stages.
// ----------------------------------------------------------------------------
module wtc_angle import wtc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_rot,
  input  pay_t        in_pay,
  output logic        out_valid,
  input  logic        out_ready,
  output ang_t        out_ang,
  output pay_t        out_pay
);

  localparam int SH = ANG_BITS - FRAC_BITS;
  localparam int QS = 62 - SH;
  localparam int NS = 3;
  // floor(2^62 / 2pi), below 2^30
  localparam logic signed [31:0] RECIP32 = 32'((longint'(1) << 62) / ANG_TWO_PI);
  localparam logic signed [57:0] M58  = 58'(ANG_TWO_PI);
  localparam logic signed [35:0] M36  = 36'(ANG_TWO_PI);
  localparam logic signed [35:0] PI36 = 36'(ANG_PI);
  localparam logic signed [33:0] HP34 = 34'(ANG_HALF_PI);
  localparam logic signed [33:0] PI34 = 34'(ANG_PI);

  logic [NS-1:0]      vld_r;
  logic [NS:0]        rdy;
  pay_t               pay_r [NS];
  logic signed [62:0] prod_r;
  logic signed [62:0] prod_nxt;
  logic signed [31:0] rot_r;
  logic signed [35:0] rem_r;
  logic signed [35:0] rem_nxt;
  ang_t               ang_r;
  ang_t               ang_nxt;

  // Ready chain: a stage loads when empty or when its successor moves
  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Carried payload
  always_ff @(posedge clk) begin
    if (rdy[0]) pay_r[0] <= in_pay;
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) pay_r[k] <= pay_r[k-1];
    end
  end

  // Stage 0: rotation times the reciprocal of two pi
  always_comb begin
    prod_nxt = 63'($signed(in_rot)) * 63'(RECIP32);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod_r <= prod_nxt;
      rot_r  <= $signed(in_rot);
    end
  end

  // Stage 1: remainder against the estimated turn count, within -2pi..4pi
  always_comb begin
    logic signed [62:0] q;
    logic signed [57:0] zw;
    logic signed [57:0] qm;
    logic signed [57:0] r;
    q  = prod_r >>> QS;
    zw = 58'(rot_r) <<< SH;
    qm = 58'($signed(q[23:0])) * M58;
    r  = zw - qm;
    rem_nxt = r[35:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) rem_r <= rem_nxt;
  end

  // Stage 2: correct to 0..2pi, wrap to -pi..pi, fold to the right half plane
  always_comb begin
    logic signed [35:0] rc;
    logic signed [33:0] zs;
    rc = rem_r;
    if (rc < 36'sd0) rc = rc + M36;
    else if (rc >= M36) rc = rc - M36;
    if (rc >= PI36) rc = rc - M36;
    zs = rc[33:0];
    ang_nxt.z    = zs;
    ang_nxt.flip = 1'b0;
    if (zs > HP34) begin
      ang_nxt.z    = zs - PI34;
      ang_nxt.flip = 1'b1;
    end else if (zs < -HP34) begin
      ang_nxt.z    = zs + PI34;
      ang_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) ang_r <= ang_nxt;
  end

  assign out_valid = vld_r[NS-1];
  assign out_ang   = ang_r;
  assign out_pay   = pay_r[NS-1];

endmodule

// ===== rtl/wtc_cordic.sv =====
// ----------------------------------------------------------------------------
// wtc_cordic
// Rotation-mode CORDIC, up to four iterations per register stage.
// ----------------------------------------------------------------------------
module wtc_cordic import wtc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  ang_t  in_ang,
  input  pay_t  in_pay,
  output logic  out_valid,
  input  logic  out_ready,
  output trig_t out_trig,
  output pay_t  out_pay
);

  localparam int NC = (CORDIC_STEPS + 3) / 4;
  localparam logic signed [33:0] GAIN34 = 34'(CORDIC_GAIN);

  logic [NC-1:0]      vld_r;
  logic [NC:0]        rdy;
  pay_t               pay_r  [NC];
  logic signed [33:0] x_r    [NC];
  logic signed [33:0] y_r    [NC];
  logic signed [33:0] z_r    [NC];
  logic [NC-1:0]      flip_r;
  logic signed [33:0] x_nxt  [NC];
  logic signed [33:0] y_nxt  [NC];
  logic signed [33:0] z_nxt  [NC];

  assign rdy[NC] = out_ready;
  for (genvar k = 0; k < NC; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  for (genvar g = 0; g < NC; g++) begin : g_stage
    logic signed [33:0] x_in;
    logic signed [33:0] y_in;
    logic signed [33:0] z_in;
    logic               flip_in;
    logic               vld_in;
    pay_t               pay_in;
    if (g == 0) begin : g_src0
      assign x_in    = GAIN34;
      assign y_in    = '0;
      assign z_in    = in_ang.z;
      assign flip_in = in_ang.flip;
      assign vld_in  = in_valid;
      assign pay_in  = in_pay;
    end else begin : g_srcn
      assign x_in    = x_r[g-1];
      assign y_in    = y_r[g-1];
      assign z_in    = z_r[g-1];
      assign flip_in = flip_r[g-1];
      assign vld_in  = vld_r[g-1];
      assign pay_in  = pay_r[g-1];
    end

    // Up to four micro-rotations
    always_comb begin
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic signed [33:0] nx;
      x  = x_in;
      y  = y_in;
      z  = z_in;
      nx = '0;
      for (int i = 0; i < 4; i++) begin
        if (g * 4 + i < CORDIC_STEPS) begin
          if (!z[33]) begin
            nx = x - (y >>> (g * 4 + i));
            y  = y + (x >>> (g * 4 + i));
            z  = z - $signed({4'b0, ATAN_TAB[5'(g * 4 + i)]});
          end else begin
            nx = x + (y >>> (g * 4 + i));
            y  = y - (x >>> (g * 4 + i));
            z  = z + $signed({4'b0, ATAN_TAB[5'(g * 4 + i)]});
          end
          x = nx;
        end
      end
      x_nxt[g] = x;
      y_nxt[g] = y;
      z_nxt[g] = z;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g] <= 1'b0;
      else if (rdy[g]) vld_r[g] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        x_r[g]    <= x_nxt[g];
        y_r[g]    <= y_nxt[g];
        z_r[g]    <= z_nxt[g];
        flip_r[g] <= flip_in;
        pay_r[g]  <= pay_in;
      end
    end
  end

  assign out_valid     = vld_r[NC-1];
  assign out_trig.x    = x_r[NC-1];
  assign out_trig.y    = y_r[NC-1];
  assign out_trig.flip = flip_r[NC-1];
  assign out_pay       = pay_r[NC-1];

endmodule

// ===== verif/tb_world_transform_compose_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// World transform compose unit testbench
// Drives node requests (rotation, scale, pivot, parent matrix, opacity) into
// the unit under random valid/stall gaps and compares every world matrix,
// offset and opacity against a bit-accurate fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_world_transform_compose_unit;
  import wtc_pkg::*;

  localparam int STEPS     = 24;
  localparam int FB        = 16;
  localparam int LATENCY   = 14;
  localparam int N_RANDOM  = 1400;
  localparam int WDOG_MAX  = 20000;

  typedef struct {
    logic [31:0] rotation;
    logic [63:0] scale_pair;
    logic [63:0] position_pair;
    logic [63:0] pivot_pair;
    logic [16:0] node_alpha;
    logic        has_parent;
    logic [63:0] parent_ab;
    logic [63:0] parent_cd;
    logic [63:0] parent_offset;
    logic [16:0] parent_alpha;
  } node_req_t;

  typedef struct {
    logic [63:0] world_ab;
    logic [63:0] world_cd;
    logic [63:0] world_offset;
    logic [16:0] world_alpha;
  } world_xf_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_rotation = '0;
  logic [63:0] in_scale_pair = '0;
  logic [63:0] in_position_pair = '0;
  logic [63:0] in_pivot_pair = '0;
  logic [16:0] in_node_alpha = '0;
  logic        in_has_parent = 1'b0;
  logic [63:0] in_parent_ab = '0;
  logic [63:0] in_parent_cd = '0;
  logic [63:0] in_parent_offset = '0;
  logic [16:0] in_parent_alpha = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [63:0] out_world_ab;
  logic [63:0] out_world_cd;
  logic [63:0] out_world_offset;
  logic [16:0] out_world_alpha;

  world_xf_t expected_xf_q[$];
  int  mismatch_count = 0;
  int  idle_pct = 26;        // shared idling rate, 0 during quiet stretch
  bit  hold_results = 1'b0;  // long receiver hold-off requested
  int  wdog = 0;

  always #5 clk = ~clk;

  world_transform_compose_unit u_top (.*);

  // ---------------- predictor ----------------
  function automatic longint lo_s(logic [63:0] v);
    return longint'($signed(v[31:0]));
  endfunction

  function automatic longint hi_s(logic [63:0] v);
    return longint'($signed(v[63:32]));
  endfunction

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // arithmetic shift is floor division for signed longint
  function automatic longint fx_mul(longint x, longint y);
    return (x * y + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint sincos_scale(longint t, longint s);
    return clamp_s32((t * s + (64'sd1 <<< 29)) >>> 30);
  endfunction

  function automatic void rotate_sincos(longint rot, output longint cs, output longint sn);
    longint z, x, y, nx;
    bit flip;
    z = rot * (64'sd1 <<< (30 - FB));
    x = CORDIC_GAIN;
    y = 0;
    flip = 1'b0;
    z = z % ANG_TWO_PI;
    if (z < 0) z += ANG_TWO_PI;
    if (z >= ANG_PI) z -= ANG_TWO_PI;
    if (z > ANG_HALF_PI) begin
      z -= ANG_PI;
      flip = 1'b1;
    end else if (z < -ANG_HALF_PI) begin
      z += ANG_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic world_xf_t compose_world(node_req_t r);
    world_xf_t w;
    longint pa, pb, pc, pd, ptx, pty, al, cs, sn, a, b, c, d, tx, ty;
    longint sx, sy, vx, vy;
    pa = 64'sd1 <<< FB; pb = 0; pc = 0; pd = 64'sd1 <<< FB; ptx = 0; pty = 0;
    al = longint'(r.node_alpha);
    if (r.has_parent) begin
      pa = hi_s(r.parent_ab); pb = lo_s(r.parent_ab);
      pc = hi_s(r.parent_cd); pd = lo_s(r.parent_cd);
      ptx = hi_s(r.parent_offset); pty = lo_s(r.parent_offset);
      al = (al * longint'(r.parent_alpha) + 32768) >>> 16;
    end
    if (al > 65536) al = 65536;
    rotate_sincos(longint'($signed(r.rotation)), cs, sn);
    sx = hi_s(r.scale_pair); sy = lo_s(r.scale_pair);
    vx = hi_s(r.pivot_pair); vy = lo_s(r.pivot_pair);
    a = sincos_scale(cs, sx);
    b = sincos_scale(sn, sx);
    c = sincos_scale(-sn, sy);
    d = sincos_scale(cs, sy);
    tx = clamp_s32(hi_s(r.position_pair) - (fx_mul(vx, a) + fx_mul(vy, c)));
    ty = clamp_s32(lo_s(r.position_pair) - (fx_mul(vx, b) + fx_mul(vy, d)));
    w.world_ab = {32'(clamp_s32(fx_mul(a, pa) + fx_mul(b, pc))),
                  32'(clamp_s32(fx_mul(a, pb) + fx_mul(b, pd)))};
    w.world_cd = {32'(clamp_s32(fx_mul(c, pa) + fx_mul(d, pc))),
                  32'(clamp_s32(fx_mul(c, pb) + fx_mul(d, pd)))};
    w.world_offset = {32'(clamp_s32(fx_mul(tx, pa) + fx_mul(ty, pc) + ptx)),
                      32'(clamp_s32(fx_mul(tx, pb) + fx_mul(ty, pd) + pty))};
    w.world_alpha = 17'(al);
    return w;
  endfunction

  function automatic bit xf_differs(world_xf_t p, world_xf_t q);
    return p.world_ab !== q.world_ab || p.world_cd !== q.world_cd ||
           p.world_offset !== q.world_offset || p.world_alpha !== q.world_alpha;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      4: return 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
      default: return 32'($signed($urandom_range(0, 1024 << 16)) - (512 << 16));
    endcase
  endfunction

  function automatic node_req_t rand_node();
    node_req_t r;
    r.rotation = $urandom_range(0, 3) == 0 ? $urandom()
               : 32'($signed($urandom_range(0, 14 << 16)) - (7 << 16));
    r.scale_pair    = {rand_q(), rand_q()};
    r.position_pair = {rand_q(), rand_q()};
    r.pivot_pair    = {rand_q(), rand_q()};
    r.node_alpha    = $urandom_range(0, 3) == 0 ? 17'($urandom()) : 17'($urandom_range(0, 65536));
    r.has_parent    = $urandom_range(0, 3) != 0;
    r.parent_ab     = {rand_q(), rand_q()};
    r.parent_cd     = {rand_q(), rand_q()};
    r.parent_offset = {rand_q(), rand_q()};
    r.parent_alpha  = $urandom_range(0, 3) == 0 ? 17'($urandom()) : 17'($urandom_range(0, 65536));
    return r;
  endfunction

  function automatic node_req_t mk_node(logic [31:0] rot, logic [63:0] sc, logic [63:0] pos,
                                        logic [63:0] piv, logic [16:0] na, logic hp,
                                        logic [63:0] pab, logic [63:0] pcd,
                                        logic [63:0] poff, logic [16:0] pal);
    node_req_t r;
    r.rotation = rot; r.scale_pair = sc; r.position_pair = pos; r.pivot_pair = piv;
    r.node_alpha = na; r.has_parent = hp; r.parent_ab = pab; r.parent_cd = pcd;
    r.parent_offset = poff; r.parent_alpha = pal;
    return r;
  endfunction

  // Send one request; valid may stay high across back-to-back requests
  task automatic send_request(node_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_rotation      <= r.rotation;
    in_scale_pair    <= r.scale_pair;
    in_position_pair <= r.position_pair;
    in_pivot_pair    <= r.pivot_pair;
    in_node_alpha    <= r.node_alpha;
    in_has_parent    <= r.has_parent;
    in_parent_ab     <= r.parent_ab;
    in_parent_cd     <= r.parent_cd;
    in_parent_offset <= r.parent_offset;
    in_parent_alpha  <= r.parent_alpha;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_xf_q.push_back(compose_world(r));
  endtask

  // ---------------- directed table ----------------
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [63:0] ID_AB = {ONE, 32'h0};
  localparam logic [63:0] ID_CD = {32'h0, ONE};
  localparam int N_DIR = 14;
  node_req_t dir_tab[N_DIR];
  world_xf_t dir_want[N_DIR];
  bit        dir_has_want[N_DIR];

  initial begin
    // zero rotation, unit scale, no parent: identity
    dir_tab[0] = mk_node(0, {ONE, ONE}, 0, 0, 17'd65536, 0, 0, 0, 0, 0);
    // zero scale collapses the matrix, position passes through
    dir_tab[1] = mk_node(32'h0003_0000, 0, {32'h0005_0000, 32'hfffd_0000}, 64'h1234,
                         17'd32768, 0, 0, 0, 0, 0);
    // alpha above one on both sides saturates to one
    dir_tab[2] = mk_node(0, 0, 0, 0, 17'h1ffff, 1, 0, 0, 0, 17'h1ffff);
    dir_tab[3] = mk_node(32'h7fffffff, {32'h7fffffff, 32'h7fffffff},
                         {32'h7fffffff, 32'h80000000}, {32'h80000000, 32'h7fffffff},
                         17'd0, 1, {32'h7fffffff, 32'h80000000},
                         {32'h80000000, 32'h7fffffff}, {32'h7fffffff, 32'h80000000},
                         17'd65536);
    dir_tab[4] = mk_node(32'h80000000, {32'h80000000, 32'h80000000}, '1, '1, 17'd1, 1,
                         '1, '1, '1, 17'd1);
    // near plus/minus pi/2 and pi (fold paths)
    dir_tab[5] = mk_node(32'h0001_921f, {ONE, ONE}, 0, {ONE, ONE}, 17'd65536, 0, 0, 0, 0, 0);
    dir_tab[6] = mk_node(32'hfffe_6de1, {ONE, ONE}, 0, {ONE, ONE}, 17'd65536, 0, 0, 0, 0, 0);
    dir_tab[7] = mk_node(32'h0003_243f, {ONE, ONE}, 0, 0, 17'd65536, 0, 0, 0, 0, 0);
    dir_tab[8] = mk_node(32'hfffc_dbc1, {ONE, ONE}, 0, 0, 17'd65536, 0, 0, 0, 0, 0);
    // several turns out
    dir_tab[9] = mk_node(32'h0064_0000, {ONE, 32'h0002_0000}, 0, 0, 17'd65536, 0, 0, 0, 0, 0);
    // identity parent with offset
    dir_tab[10] = mk_node(32'h0000_8000, {ONE, ONE}, {ONE, ONE}, 0, 17'd65536, 1,
                          ID_AB, ID_CD, {32'h0010_0000, 32'hfff0_0000}, 17'd65536);
    dir_tab[11] = mk_node(32'hffff_0000, {32'h0000_8000, 32'hffff_0000}, {ONE, 0},
                          {32'h0003_0000, 32'hffff_8000}, 17'd40000, 1,
                          {32'h0, ONE}, {32'hffff_0000, 32'h0}, {ONE, ONE}, 17'd50000);
    // all-zero parent matrix wipes the world transform
    dir_tab[12] = mk_node(0, {ONE, ONE}, 0, 0, 17'd0, 1, 0, 0, 0, 17'd65536);
    dir_tab[13] = mk_node(32'h5555_5555, 64'haaaa_aaaa_5555_5555, 64'h5555_5555_aaaa_aaaa,
                          64'haaaa_aaaa_5555_5555, 17'h0aaaa, 1, 64'h5555_5555_aaaa_aaaa,
                          64'haaaa_aaaa_5555_5555, 64'h5555_5555_aaaa_aaaa, 17'h15555);
    foreach (dir_has_want[i]) dir_has_want[i] = 1'b0;
    // values readable at a glance
    dir_want[0] = '{ID_AB, ID_CD, 64'h0, 17'd65536};
    dir_has_want[0] = 1'b1;
    dir_want[1] = '{64'h0, 64'h0, {32'h0005_0000, 32'hfffd_0000}, 17'd32768};
    dir_has_want[1] = 1'b1;
    dir_want[2] = '{64'h0, 64'h0, 64'h0, 17'd65536};
    dir_has_want[2] = 1'b1;
    dir_want[12] = '{64'h0, 64'h0, 64'h0, 17'd0};
    dir_has_want[12] = 1'b1;
  end

  // ---------------- sender ----------------
  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_has_want[i] && xf_differs(compose_world(dir_tab[i]), dir_want[i])) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("predictor disagrees with table row %0d", i);
      end
      send_request(dir_tab[i]);
    end
    n = 0;
    while (n < N_RANDOM) begin
      // quiet stretch: back-to-back requests, no receiver stalls
      if (n == 300) idle_pct = 0;
      if (n == 500) idle_pct = 26;
      // receiver hold-off while requests keep coming
      if (n == 700) hold_results = 1'b1;
      // sender pause until the pipe drains
      if (n == 1000) begin
        in_valid <= 1'b0;
        while (expected_xf_q.size() != 0) @(posedge clk);
      end
      send_request(rand_node());
      n++;
    end
    in_valid <= 1'b0;
    while (expected_xf_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // ---------------- receiver stall ----------------
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        hold_results = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct);
      @(posedge clk);
    end
  end

  // ---------------- checker and watchdog ----------------
  always @(posedge clk) begin
    world_xf_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_xf_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", out_world_ab);
      end else begin
        want = expected_xf_q.pop_front();
        if (out_world_ab !== want.world_ab || out_world_cd !== want.world_cd ||
            out_world_offset !== want.world_offset || out_world_alpha !== want.world_alpha) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch ab %h/%h cd %h/%h off %h/%h alpha %h/%h (exp/got)",
                     want.world_ab, out_world_ab, want.world_cd, out_world_cd,
                     want.world_offset, out_world_offset, want.world_alpha,
                     out_world_alpha);
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
    else if (wdog >= WDOG_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end else wdog <= wdog + 1;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wtc_pkg.sv
rtl/wtc_angle.sv
rtl/wtc_cordic.sv
rtl/world_transform_compose_unit.sv
verif/tb_world_transform_compose_unit.sv
